// File: rtl/core/mvol_pkg.sv
// shared types, constants and helpers for the video object layer header parser
// no dependencies; used by mvol_bit_step, mvol_byte_step and the top level
`timescale 1ns / 1ps

package mvol_pkg;

    // header field constants
    localparam logic [3:0] AR_EXTENDED = 4'd15;
    localparam logic [1:0] SHAPE_GRAY  = 2'd3;
    localparam logic [1:0] SHAPE_RECT  = 2'd0;
    localparam logic [3:0] VERID_ONE   = 4'd1;
    localparam int         RES_BITS    = 16;
    localparam int         DIM_BITS    = 13;
    localparam int         BYTE_BITS   = 8;

    // walk position through the header
    typedef enum logic [4:0] {
        PH_IDLE, PH_RAND, PH_TYPE, PH_IDFLAG, PH_VERID, PH_PRIO, PH_ASPECT,
        PH_PARW, PH_PARH, PH_CTRL, PH_CHROMA, PH_LOWDELAY, PH_VBVFLAG,
        PH_VBV1, PH_VBV2, PH_VBV3, PH_VBV4, PH_VBV5, PH_SHAPE, PH_SHAPEEXT,
        PH_MARK1, PH_RES, PH_MARK2, PH_FIXED, PH_INC, PH_MARK3, PH_WIDTH,
        PH_MARK4, PH_HEIGHT
    } phase_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_RES = 2'd1,
        ST_SHAPE    = 2'd2
    } status_t;

    // complete parser state carried from byte to byte
    typedef struct packed {
        phase_t                phase;
        logic [4:0]            bits_left;
        logic [15:0]           accum;
        logic [3:0]            verid;
        logic [1:0]            shape;
        logic [4:0]            inc_width;
        logic [RES_BITS-1:0]   resolution;
        logic [15:0]           increment;
        logic [DIM_BITS-1:0]   width;
    } parse_state_t;

    // one result
    typedef struct packed {
        status_t               status;
        logic [DIM_BITS-1:0]   frame_width;
        logic [DIM_BITS-1:0]   frame_height;
        logic [RES_BITS-1:0]   time_resolution;
        logic [15:0]           time_increment;
    } result_t;

    localparam parse_state_t RESET_STATE = '{
        phase:      PH_IDLE,
        bits_left:  5'd0,
        accum:      16'd0,
        verid:      4'd1,
        shape:      2'd0,
        inc_width:  5'd1,
        resolution: 16'd0,
        increment:  16'd1,
        width:      13'd0
    };

    // field length of each fixed-width phase
    function automatic logic [4:0] phase_bits(input phase_t p);
        logic [4:0] n;
        case (p)
            PH_RAND:     n = 5'd1;
            PH_TYPE:     n = 5'd8;
            PH_IDFLAG:   n = 5'd1;
            PH_VERID:    n = 5'd4;
            PH_PRIO:     n = 5'd3;
            PH_ASPECT:   n = 5'd4;
            PH_PARW:     n = 5'd8;
            PH_PARH:     n = 5'd8;
            PH_CTRL:     n = 5'd1;
            PH_CHROMA:   n = 5'd2;
            PH_LOWDELAY: n = 5'd1;
            PH_VBVFLAG:  n = 5'd1;
            PH_VBV1:     n = 5'd16;
            PH_VBV2:     n = 5'd16;
            PH_VBV3:     n = 5'd16;
            PH_VBV4:     n = 5'd16;
            PH_VBV5:     n = 5'd15;
            PH_SHAPE:    n = 5'd2;
            PH_SHAPEEXT: n = 5'd4;
            PH_MARK1:    n = 5'd1;
            PH_RES:      n = 5'(RES_BITS);
            PH_MARK2:    n = 5'd1;
            PH_FIXED:    n = 5'd1;
            PH_MARK3:    n = 5'd1;
            PH_WIDTH:    n = 5'(DIM_BITS);
            PH_MARK4:    n = 5'd1;
            PH_HEIGHT:   n = 5'(DIM_BITS);
            default:     n = 5'd0;
        endcase
        return n;
    endfunction

    // move to a new phase with a cleared accumulator
    function automatic parse_state_t enter_phase(input parse_state_t s, input phase_t p);
        parse_state_t r;
        r           = s;
        r.phase     = p;
        r.accum     = '0;
        r.bits_left = (p == PH_INC) ? s.inc_width : phase_bits(p);
        return r;
    endfunction

    // bit length of a 16-bit value, at least one
    function automatic logic [4:0] bit_length_min1(input logic [15:0] x);
        logic [4:0] len;
        len = 5'd1;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                len = 5'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// File: rtl/core/mvol_bit_step.sv
// one header bit: shift into the field accumulator and act on a finished field
// depends on mvol_pkg
`timescale 1ns / 1ps

module mvol_bit_step (
    input  mvol_pkg::parse_state_t cur_state,
    input  logic                   bit_in,
    output mvol_pkg::parse_state_t next_state,
    output logic                   emit,
    output mvol_pkg::result_t      result
);

    logic [15:0]            acc;
    logic [4:0]             left;
    mvol_pkg::parse_state_t nx;

    assign acc  = {cur_state.accum[14:0], bit_in};
    assign left = (cur_state.bits_left != 5'd0) ? cur_state.bits_left - 5'd1 : 5'd0;

    // field walk
    always_comb begin
        nx     = cur_state;
        emit   = 1'b0;
        result = '0;
        if (cur_state.phase != mvol_pkg::PH_IDLE) begin
            nx.accum     = acc;
            nx.bits_left = left;
            if (left == 5'd0) begin
                case (cur_state.phase)
                    mvol_pkg::PH_IDFLAG: begin
                        if (acc[0]) begin
                            nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_VERID);
                        end else begin
                            nx.verid = mvol_pkg::VERID_ONE;
                            nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_ASPECT);
                        end
                    end
                    mvol_pkg::PH_VERID: begin
                        nx.verid = acc[3:0];
                        nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_PRIO);
                    end
                    mvol_pkg::PH_ASPECT: begin
                        nx = mvol_pkg::enter_phase(nx, (acc[3:0] == mvol_pkg::AR_EXTENDED) ?
                                                   mvol_pkg::PH_PARW : mvol_pkg::PH_CTRL);
                    end
                    mvol_pkg::PH_PARH: begin
                        nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_CTRL);
                    end
                    mvol_pkg::PH_CTRL: begin
                        nx = mvol_pkg::enter_phase(nx, acc[0] ? mvol_pkg::PH_CHROMA :
                                                                mvol_pkg::PH_SHAPE);
                    end
                    mvol_pkg::PH_VBVFLAG: begin
                        nx = mvol_pkg::enter_phase(nx, acc[0] ? mvol_pkg::PH_VBV1 :
                                                                mvol_pkg::PH_SHAPE);
                    end
                    mvol_pkg::PH_VBV5: begin
                        nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_SHAPE);
                    end
                    mvol_pkg::PH_SHAPE: begin
                        nx.shape = acc[1:0];
                        nx = mvol_pkg::enter_phase(nx,
                            (acc[1:0] == mvol_pkg::SHAPE_GRAY &&
                             cur_state.verid != mvol_pkg::VERID_ONE) ?
                            mvol_pkg::PH_SHAPEEXT : mvol_pkg::PH_MARK1);
                    end
                    mvol_pkg::PH_RES: begin
                        nx.resolution = acc;
                        if (acc == 16'd0) begin
                            nx.increment = 16'd1;
                            emit = 1'b1;
                            result.status = mvol_pkg::ST_ZERO_RES;
                            nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_IDLE);
                        end else begin
                            nx.inc_width = mvol_pkg::bit_length_min1(acc - 16'd1);
                            nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_MARK2);
                        end
                    end
                    mvol_pkg::PH_FIXED, mvol_pkg::PH_INC: begin
                        if (cur_state.phase == mvol_pkg::PH_FIXED && acc[0]) begin
                            nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_INC);
                        end else begin
                            nx.increment = (cur_state.phase == mvol_pkg::PH_INC) ? acc : 16'd1;
                            // non-rectangular shape ends the walk here
                            if (cur_state.shape != mvol_pkg::SHAPE_RECT) begin
                                emit = 1'b1;
                                result.status = mvol_pkg::ST_SHAPE;
                                nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_IDLE);
                            end else begin
                                nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_MARK3);
                            end
                        end
                    end
                    mvol_pkg::PH_WIDTH: begin
                        nx.width = acc[mvol_pkg::DIM_BITS-1:0];
                        nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_MARK4);
                    end
                    mvol_pkg::PH_HEIGHT: begin
                        emit = 1'b1;
                        result.status       = mvol_pkg::ST_OK;
                        result.frame_width  = cur_state.width;
                        result.frame_height = acc[mvol_pkg::DIM_BITS-1:0];
                        nx = mvol_pkg::enter_phase(nx, mvol_pkg::PH_IDLE);
                    end
                    default: begin
                        nx = mvol_pkg::enter_phase(nx,
                            mvol_pkg::phase_t'(5'(cur_state.phase) + 5'd1));
                    end
                endcase
                result.time_resolution = nx.resolution;
                result.time_increment  = nx.increment;
            end
        end
    end

    assign next_state = nx;

endmodule

// File: rtl/core/mvol_byte_step.sv
// one header byte: start handling and eight chained bit steps, msb first
// depends on mvol_pkg and mvol_bit_step
`timescale 1ns / 1ps

module mvol_byte_step (
    input  mvol_pkg::parse_state_t cur_state,
    input  logic [7:0]             data_byte,
    input  logic                   start_req,
    output mvol_pkg::parse_state_t next_state,
    output logic                   emit,
    output mvol_pkg::result_t      result
);

    mvol_pkg::parse_state_t chain [0:mvol_pkg::BYTE_BITS];
    logic [mvol_pkg::BYTE_BITS-1:0] step_emit;
    mvol_pkg::result_t      step_res [0:mvol_pkg::BYTE_BITS-1];

    assign chain[0] = cur_state;

    // bit steps, most significant bit first
    for (genvar i = 0; i < mvol_pkg::BYTE_BITS; i++) begin : g_bit
        mvol_bit_step u_bit (
            .cur_state  (chain[i]),
            .bit_in     (data_byte[mvol_pkg::BYTE_BITS-1-i]),
            .next_state (chain[i+1]),
            .emit       (step_emit[i]),
            .result     (step_res[i])
        );
    end

    // at most one step finishes the header; the walk is idle after it
    always_comb begin
        result = '0;
        for (int i = 0; i < mvol_pkg::BYTE_BITS; i++) begin
            if (step_emit[i]) begin
                result = step_res[i];
            end
        end
    end

    // a start byte drops any walk in progress and begins a new one
    always_comb begin
        if (start_req) begin
            next_state = mvol_pkg::enter_phase(mvol_pkg::RESET_STATE, mvol_pkg::PH_RAND);
            emit       = 1'b0;
        end else begin
            next_state = chain[mvol_pkg::BYTE_BITS];
            emit       = |step_emit;
        end
    end

endmodule

// File: rtl/core/mpeg4_vol_header_parser.sv
// top level of the video object layer header parser: request registers and handshakes
// depends on mvol_pkg and mvol_byte_step
`timescale 1ns / 1ps

// The parser takes one header byte per cycle on the s_ channel; a request with
// s_start_req high marks the last start code byte and restarts the walk, and
// the bytes after it are parsed msb first. Throughput is one byte every cycle
// while the result side is ready; each accepted byte is held in an input
// register and, once the result slot is free, passes through eight chained bit
// steps into the parser state and, when it completes the header, into the result
// register. A result therefore shows on m_valid from the result register, fed
// by the input register that accepted the byte finishing it; a waiting result
// with m_ready low holds the input register and so stalls s_ready.
// At most one result follows each start: status ok with the frame size, zero
// time resolution, or non-rectangular shape; a start in the middle of a header
// drops that walk with no result. Bytes after a result and before the next
// start are taken and dropped.

module mpeg4_vol_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [12:0] m_frame_width,
    output logic [12:0] m_frame_height,
    output logic [15:0] m_time_resolution,
    output logic [15:0] m_time_increment
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg, in_byte_next;
    logic                   in_start_reg, in_start_next;
    mvol_pkg::parse_state_t state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    mvol_pkg::result_t      result_reg, result_next;

    mvol_pkg::parse_state_t step_state;
    logic                   step_emit;
    mvol_pkg::result_t      step_res;
    logic                   advance;

    mvol_byte_step u_byte (
        .cur_state  (state_reg),
        .data_byte  (in_byte_reg),
        .start_req  (in_start_reg),
        .next_state (step_state),
        .emit       (step_emit),
        .result     (step_res)
    );

    // held request moves on once the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // next values
    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_start_next  = in_start_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_data_byte;
            in_start_next = s_start_req;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            state_next = step_state;
            if (step_emit) begin
                out_valid_next = 1'b1;
                result_next    = step_res;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= mvol_pkg::RESET_STATE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        in_start_reg <= in_start_next;
        result_reg   <= result_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = result_reg.status;
    assign m_frame_width     = result_reg.frame_width;
    assign m_frame_height    = result_reg.frame_height;
    assign m_time_resolution = result_reg.time_resolution;
    assign m_time_increment  = result_reg.time_increment;

endmodule
